@@ rtl/lni_pkg.sv @@
// Shared types, constants and per-stage datapath function for the lattice neighbor index core.
// Used by lni_cfg, lattice_neighbor_index_core and the testbench; depends on nothing else.
`timescale 1ns / 1ps
package lni_pkg;

   localparam int MAX_SITES  = 4096;
   localparam int MAX_DIMS   = 4;
   localparam int SITE_W     = $clog2(MAX_SITES);
   localparam int STEP_W     = 7;
   localparam int EXT_W      = 7;
   localparam int EXT_CAP    = 64;
   localparam int CSR_ADDR_W = 3;

   // Pipeline layout: five stages per dimension (four division stages and
   // one finish stage), then multiply, accumulate and status stages.
   localparam int DIM_STAGES = 5;
   localparam int DIV_STAGES = DIM_STAGES * MAX_DIMS;
   localparam int MUL_STAGE  = DIV_STAGES;
   localparam int ACC_STAGE  = DIV_STAGES + 1;
   localparam int NUM_STAGES = DIV_STAGES + 3;
   localparam int FIN_STEP   = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT3 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WRAP    = 3'd4;

   typedef enum logic [1:0] {
      ST_CONNECTED = 2'd0,
      ST_OPEN      = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

   typedef struct packed {
      logic [MAX_DIMS-1:0][EXT_W-1:0] ext;   // effective extents, 1..64
      logic [MAX_DIMS-1:0]            wrap;
   } cfg_type;

   typedef struct packed {
      logic [SITE_W-1:0]              num;    // running quotient
      logic [5:0]                     rem;    // coordinate remainder
      logic [STEP_W-1:0]              snum;   // step magnitude being reduced
      logic [5:0]                     srem;   // step magnitude mod extent
      logic [MAX_DIMS-1:0][STEP_W-1:0] step;
      logic [5:0]                     y;
      logic                           crossed;
      logic [SITE_W-1:0]              prod;
      logic [SITE_W-1:0]              acc;
      logic [SITE_W-1:0]              radix;
      logic [SITE_W:0]                tot;
      logic                           over;
      logic [SITE_W-1:0]              nbr;
      status_type                     status;
   } pipe_type;

   function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] raw);
      logic [EXT_W-1:0] e;
      e = raw;
      if (raw == '0) begin
         e = EXT_W'(1);
      end else if (raw > EXT_W'(EXT_CAP)) begin
         e = EXT_W'(EXT_CAP);
      end
      return e;
   endfunction

   // One pipeline stage. dim and step_no locate the stage within a dimension,
   // stage_no selects the closing stages.
   function automatic pipe_type stage_fn(input pipe_type p, input int dim, input int step_no,
                                         input int stage_no, input cfg_type c);
      pipe_type           q;
      logic [EXT_W-1:0]   e;
      logic [EXT_W-1:0]   ep;
      logic [6:0]         t;
      logic               ge;
      int                 nsteps;
      logic [STEP_W-1:0]  s;
      logic [6:0]         m;
      logic [7:0]         sum;
      logic signed [8:0]  ys;
      logic [SITE_W+5:0]  mul_y;
      logic [SITE_W+6:0]  mul_r;
      logic [SITE_W+7:0]  mul_t;
      q      = p;
      e      = c.ext[dim];
      // The closing stages fold in the last dimension's own extent.
      ep     = (stage_no < DIV_STAGES) ? c.ext[(dim > 0) ? dim - 1 : 0] : e;
      nsteps = (step_no == 3) ? 1 : 2;
      s      = p.step[dim];
      mul_y  = p.radix * p.y;
      mul_r  = p.radix * ep;
      mul_t  = p.tot * ep;
      if (stage_no < DIV_STAGES) begin
         if (step_no < FIN_STEP) begin
            if (step_no == 0) begin
               q.rem  = '0;
               q.srem = '0;
               q.snum = s[STEP_W-1] ? STEP_W'(-s) : s;
            end
            for (int i = 0; i < 3; i++) begin
               t     = {q.rem, q.num[SITE_W-1]};
               ge    = (t >= e);
               q.num = {q.num[SITE_W-2:0], ge};
               if (ge) begin
                  t = t - e;
               end
               q.rem = t[5:0];
            end
            for (int i = 0; i < 2; i++) begin
               if (i < nsteps) begin
                  t      = {q.srem, q.snum[STEP_W-1]};
                  q.snum = {q.snum[STEP_W-2:0], 1'b0};
                  if (t >= e) begin
                     t = t - e;
                  end
                  q.srem = t[5:0];
               end
            end
            // Fold the previous dimension into the running index.
            if (dim > 0) begin
               if (step_no == 0) begin
                  q.prod = mul_y[SITE_W-1:0];
               end else if (step_no == 1) begin
                  q.acc   = p.acc + p.prod;
                  q.radix = mul_r[SITE_W-1:0];
                  q.tot   = mul_t[SITE_W:0];
                  if (mul_t > (SITE_W+8)'(MAX_SITES)) begin
                     q.over = 1'b1;
                  end
               end
            end
         end else begin
            if (c.wrap[dim]) begin
               m   = (s[STEP_W-1] && (p.srem != '0)) ? (e - {1'b0, p.srem}) : {1'b0, p.srem};
               sum = {2'b00, p.rem} + {1'b0, m};
               if (sum >= {1'b0, e}) begin
                  sum = sum - {1'b0, e};
               end
               q.y = sum[5:0];
            end else begin
               ys = $signed({3'b000, p.rem}) + $signed({{2{s[STEP_W-1]}}, s});
               if ((ys < 0) || (ys >= $signed({2'b00, e}))) begin
                  q.crossed = 1'b1;
                  q.y       = '0;
               end else begin
                  q.y = ys[5:0];
               end
            end
         end
      end else if (stage_no == MUL_STAGE) begin
         q.prod = mul_y[SITE_W-1:0];
      end else if (stage_no == ACC_STAGE) begin
         q.acc = p.acc + p.prod;
         q.tot = mul_t[SITE_W:0];
         if (mul_t > (SITE_W+8)'(MAX_SITES)) begin
            q.over = 1'b1;
         end
      end else begin
         if (p.over || (p.num != '0)) begin
            q.status = ST_RANGE;
            q.nbr    = '0;
         end else if (p.crossed) begin
            q.status = ST_OPEN;
            q.nbr    = '0;
         end else begin
            q.status = ST_CONNECTED;
            q.nbr    = p.acc;
         end
      end
      return q;
   endfunction

endpackage

@@ rtl/lattice_neighbor_index_core.sv @@
// Top level of the lattice neighbor index core: request/response streams and the pipeline.
// Depends on lni_pkg and lni_cfg.
`timescale 1ns / 1ps
//
//   Channel   Direction  Width  Contents
//   req_*     in         40     site_index, step_dim0..step_dim3
//   rsp_*     out        16     neighbor_index, status
//   csr_*     in         3+7    register index and write data, no read-back
//
// The core takes one request per clock while the output slot is free or being drained, and
// returns one response for each, in order. The 23-stage pipeline holds, per dimension,
// four stages of a 3-bit-per-stage restoring divider and one finish stage, then multiply,
// accumulate and status stages.
// Reset clears only the stage valid bits and the wrap modes, and sets every extent to one.
// When the response is not taken the whole pipeline holds; nothing is dropped or repeated.
module lattice_neighbor_index_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,   // site_index, step_dim0..3 (LSB first)
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // neighbor_index, status, zero pad
   input  logic                            csr_we,
   input  logic [lni_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lni_pkg::EXT_W-1:0]       csr_wdata
);

   localparam int Last = lni_pkg::NUM_STAGES - 1;

   lni_pkg::cfg_type  cfg;
   lni_pkg::pipe_type entry;
   lni_pkg::pipe_type pipe_in [lni_pkg::NUM_STAGES];
   lni_pkg::pipe_type pipe_ff [lni_pkg::NUM_STAGES];
   logic [lni_pkg::NUM_STAGES-1:0] valid_ff;
   logic advance;

   lni_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The whole pipeline moves together whenever the output slot is free or being drained.
   assign advance    = !valid_ff[Last] || rsp_tready;
   assign req_tready = advance;

   // Unpack the request into the first stage record.
   always_comb begin
      entry         = '0;
      entry.num     = req_tdata[lni_pkg::SITE_W-1:0];
      for (int d = 0; d < lni_pkg::MAX_DIMS; d++) begin
         entry.step[d] = req_tdata[lni_pkg::SITE_W + d*lni_pkg::STEP_W +: lni_pkg::STEP_W];
      end
      entry.radix   = lni_pkg::SITE_W'(1);
      entry.tot     = (lni_pkg::SITE_W+1)'(1);
      entry.status  = lni_pkg::ST_CONNECTED;
   end

   for (genvar gk = 0; gk < lni_pkg::NUM_STAGES; gk++) begin : g_stage
      localparam int StageDim  = (gk < lni_pkg::DIV_STAGES) ? gk / lni_pkg::DIM_STAGES
                                                             : lni_pkg::MAX_DIMS - 1;
      localparam int StageStep = gk % lni_pkg::DIM_STAGES;

      if (gk == 0) begin : g_first
         always_comb begin
            pipe_in[gk] = lni_pkg::stage_fn(entry, StageDim, StageStep, gk, cfg);
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[gk] <= 1'b0;
            end else if (advance) begin
               valid_ff[gk] <= req_tvalid;
            end
         end
      end else begin : g_rest
         always_comb begin
            pipe_in[gk] = lni_pkg::stage_fn(pipe_ff[gk-1], StageDim, StageStep, gk, cfg);
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[gk] <= 1'b0;
            end else if (advance) begin
               valid_ff[gk] <= valid_ff[gk-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pipe_ff[gk] <= pipe_in[gk];
         end
      end
   end

   assign rsp_tvalid = valid_ff[Last];
   assign rsp_tdata  = {2'b00, pipe_ff[Last].status, pipe_ff[Last].nbr};

   // A response that is not connected never carries an index.
   a_zero_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (pipe_ff[Last].status != lni_pkg::ST_CONNECTED) |-> pipe_ff[Last].nbr == '0)
      else $error("nonzero index with fault status");

   // A request transfer always loads the first stage.
   a_entry_loaded: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted request missing from first stage");

   // While the output is blocked no valid bit moves.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved during stall");

   // The reserved status code never appears.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pipe_ff[Last].status == lni_pkg::ST_CONNECTED ||
                      pipe_ff[Last].status == lni_pkg::ST_OPEN ||
                      pipe_ff[Last].status == lni_pkg::ST_RANGE))
      else $error("reserved status code");

endmodule

@@ rtl/lni_cfg.sv @@
// Configuration registers of the lattice neighbor index core: extents and wrap modes.
// Depends on lni_pkg.
`timescale 1ns / 1ps
module lni_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lni_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lni_pkg::EXT_W-1:0]       csr_wdata,
   output lni_pkg::cfg_type                cfg
);

   logic [lni_pkg::MAX_DIMS-1:0][lni_pkg::EXT_W-1:0] ext_ff;
   logic [lni_pkg::MAX_DIMS-1:0]                     wrap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < lni_pkg::MAX_DIMS; d++) begin
            ext_ff[d] <= lni_pkg::EXT_W'(1);
         end
         wrap_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            lni_pkg::CSR_EXTENT0: ext_ff[0] <= csr_wdata;
            lni_pkg::CSR_EXTENT1: ext_ff[1] <= csr_wdata;
            lni_pkg::CSR_EXTENT2: ext_ff[2] <= csr_wdata;
            lni_pkg::CSR_EXTENT3: ext_ff[3] <= csr_wdata;
            lni_pkg::CSR_WRAP:    wrap_ff   <= csr_wdata[lni_pkg::MAX_DIMS-1:0];
            default: ;
         endcase
      end
   end

   // Zero reads as one site, anything above the cap as the cap.
   always_comb begin
      for (int d = 0; d < lni_pkg::MAX_DIMS; d++) begin
         cfg.ext[d] = lni_pkg::eff_extent(ext_ff[d]);
      end
      cfg.wrap = wrap_ff;
   end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for lattice_neighbor_index_core: directed and random neighbor queries
// under several lattice geometries, checked in order against a built-in lattice predictor.
// Depends on lni_pkg and the core RTL only.
`timescale 1ns / 1ps

// Expected answer for one query.
typedef struct {
   logic [11:0]         nbr;
   lni_pkg::status_type status;
} lattice_answer_type;

// Keeps the current geometry, predicts each answer and checks answers in order.
class lattice_scoreboard;
   logic [6:0]         extent_raw[4];
   logic [3:0]         periodic;
   lattice_answer_type answers_due[$];
   int                 mismatches;
   int                 answers_seen;

   function new();
      for (int d = 0; d < 4; d++) begin
         extent_raw[d] = 7'd1;
      end
      periodic     = 4'd0;
      mismatches   = 0;
      answers_seen = 0;
   endfunction

   function int sites_along(int d);
      if (extent_raw[d] == 7'd0) begin
         return 1;
      end
      if (extent_raw[d] > 7'd64) begin
         return 64;
      end
      return int'(extent_raw[d]);
   endfunction

   function int lattice_sites();
      int total;
      total = 1;
      for (int d = 0; d < 4; d++) begin
         total *= sites_along(d);
      end
      return total;
   endfunction

   // Works out the displaced site for one accepted query.
   function void note_query(logic [11:0] site, logic [3:0][6:0] steps);
      lattice_answer_type a;
      int total;
      int rest;
      int radix;
      int e;
      int y;
      int acc;
      bit crossed;
      total   = lattice_sites();
      crossed = 0;
      acc     = 0;
      radix   = 1;
      rest    = int'(site);
      if (total > lni_pkg::MAX_SITES || int'(site) >= total) begin
         a.nbr    = '0;
         a.status = lni_pkg::ST_RANGE;
      end else begin
         for (int d = 0; d < 4; d++) begin
            e    = sites_along(d);
            y    = (rest % e) + int'($signed(steps[d]));
            rest = rest / e;
            if (periodic[d]) begin
               y = ((y % e) + e) % e;
            end else if (y < 0 || y >= e) begin
               crossed = 1;
               y       = 0;
            end
            acc   += y * radix;
            radix *= e;
         end
         a.nbr    = crossed ? 12'd0 : acc[11:0];
         a.status = crossed ? lni_pkg::ST_OPEN : lni_pkg::ST_CONNECTED;
      end
      answers_due.push_back(a);
   endfunction

   function void check_answer(logic [15:0] data);
      lattice_answer_type a;
      answers_seen++;
      if (answers_due.size() == 0) begin
         $error("response with no query outstanding: %h", data);
         mismatches++;
         return;
      end
      a = answers_due.pop_front();
      if (data[11:0] !== a.nbr) begin
         $error("neighbor_index: expected %0d, got %0d", a.nbr, data[11:0]);
         mismatches++;
      end
      if (data[13:12] !== a.status) begin
         $error("status: expected %0d, got %0d", a.status, data[13:12]);
         mismatches++;
      end
   endfunction
endclass

module tb;
   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [39:0]                    req_tdata;   // site_index, step_dim0..step_dim3
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [15:0]                    rsp_tdata;   // neighbor_index, status, zero pad
   logic                           csr_we;
   logic [lni_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [lni_pkg::EXT_W-1:0]      csr_wdata;

   lattice_scoreboard     board;
   int                    cycle_count;
   int                    queries_sent;
   int                    long_hold;   // cycles the receiver still has to hold off
   int                    rx_pattern;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;   // pipeline is 23 deep; allow some margin

   lattice_neighbor_index_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a run that is still going at the limit has hung somewhere.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Every response transfer is checked against the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_answer(rsp_tdata);
      end
   end

   // Receiver back-pressure. A long hold-off, when requested, takes priority; otherwise
   // the pattern cycles through always ready, coin-flip stalls and rare stalls.
   always @(negedge clock) begin
      if (long_hold > 0) begin
         long_hold  <= long_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rx_pattern <= rx_pattern + 1;
         case ((rx_pattern / 97) % 3)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(1));
            end
            default: begin
               rsp_tready <= ($urandom_range(3) != 0);
            end
         endcase
      end
   end

   // Writes one register. Only called while no query is in flight.
   task automatic write_reg(logic [lni_pkg::CSR_ADDR_W-1:0] addr, logic [6:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      if (addr == lni_pkg::CSR_WRAP) begin
         board.periodic = value[3:0];
      end else begin
         board.extent_raw[addr] = value;
      end
   endtask

   // Waits until every predicted response has arrived and the pipeline has emptied.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.answers_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(logic [6:0] e0, logic [6:0] e1, logic [6:0] e2, logic [6:0] e3,
                               logic [3:0] wrap);
      wait_idle();
      write_reg(lni_pkg::CSR_EXTENT0, e0);
      write_reg(lni_pkg::CSR_EXTENT1, e1);
      write_reg(lni_pkg::CSR_EXTENT2, e2);
      write_reg(lni_pkg::CSR_EXTENT3, e3);
      write_reg(lni_pkg::CSR_WRAP, {3'b000, wrap});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Offers one query and holds it until the core takes the transfer. Valid stays high
   // afterward so back-to-back queries need no extra cycle.
   task automatic send_query(logic [11:0] site, logic [3:0][6:0] steps);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {steps[3], steps[2], steps[1], steps[0], site};
      do @(posedge clock); while (!req_tready);
      board.note_query(site, steps);
      queries_sent++;
   endtask

   task automatic send_steps(logic [11:0] site, int s0, int s1, int s2, int s3);
      logic [3:0][6:0] steps;
      steps[0] = s0[6:0];
      steps[1] = s1[6:0];
      steps[2] = s2[6:0];
      steps[3] = s3[6:0];
      send_query(site, steps);
   endtask

   // Half the hops are small and most sites lie inside the lattice, so most queries get past the range
   // check; the rest use the full field ranges.
   task automatic send_random_query();
      logic [3:0][6:0] steps;
      logic [11:0]     site;
      int              total;
      total = board.lattice_sites();
      for (int d = 0; d < 4; d++) begin
         if ($urandom_range(1)) begin
            steps[d] = 7'($urandom_range(6)) - 7'd3;
         end else begin
            steps[d] = 7'($urandom_range(127));
         end
      end
      if (total <= lni_pkg::MAX_SITES && $urandom_range(4) != 0) begin
         site = 12'($urandom_range(total - 1));
      end else begin
         site = 12'($urandom_range(4095));
      end
      send_query(site, steps);
   endtask

   function automatic logic [6:0] random_extent();
      case ($urandom_range(9))
         0: return 7'd0;
         1: return 7'd64;
         2: return 7'($urandom_range(127, 65));
         default: return 7'($urandom_range(8, 1));
      endcase
   endfunction

   // Bursts of random length separated by random gaps; in some phases no gaps at all.
   task automatic random_phase(int count, bit gapless);
      int burst;
      int gap;
      while (count > 0) begin
         burst = $urandom_range(24, 1);
         for (int i = 0; i < burst && count > 0; i++) begin
            send_random_query();
            count--;
         end
         gap = gapless ? 0 : $urandom_range(6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   initial begin
      board        = new();
      cycle_count  = 0;
      queries_sent = 0;
      long_hold    = 0;
      rx_pattern   = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry is a single site: only site zero with no step connects.
      send_steps(12'd0, 0, 0, 0, 0);
      send_steps(12'd1, 0, 0, 0, 0);
      send_steps(12'd0, 1, 0, 0, 0);
      send_steps(12'd4095, -64, 63, -64, 63);

      // Mixed open and periodic dimensions: 4 x 3 x 2 x 5, dimensions zero and two periodic.
      set_geometry(7'd4, 7'd3, 7'd2, 7'd5, 4'b0101);
      send_steps(12'd0, -1, 0, -1, 0);
      send_steps(12'd119, 1, 0, 1, 0);
      send_steps(12'd0, -64, 0, 63, 0);
      send_steps(12'd5, 0, -1, 0, 0);
      send_steps(12'd5, 0, 1, 0, 4);
      send_steps(12'd0, 0, -1, 0, -1);
      send_steps(12'd120, 0, 0, 0, 0);
      send_steps(12'd4095, 0, 0, 0, 0);

      // Zero extent reads as one, an oversized extent as 64; all dimensions periodic.
      set_geometry(7'd0, 7'd127, 7'd1, 7'd1, 4'b1111);
      send_steps(12'd0, -64, -64, 63, -1);
      send_steps(12'd63, 63, 63, -64, 1);

      // More sites than the core supports: every query is out of range.
      set_geometry(7'd64, 7'd64, 7'd2, 7'd1, 4'b0000);
      send_steps(12'd0, 0, 0, 0, 0);
      send_steps(12'd17, 1, 0, 0, 0);

      // The largest lattice that fits: 64 x 64 open, corner sites.
      set_geometry(7'd64, 7'd64, 7'd1, 7'd1, 4'b0000);
      send_steps(12'd4095, 0, 0, 0, 0);
      send_steps(12'd4095, -63, -63, 0, 0);
      send_steps(12'd0, 63, 63, 0, 0);
      send_steps(12'd4095, 1, 0, 0, 0);

      for (int phase = 0; phase < 10; phase++) begin
         set_geometry(random_extent(), random_extent(), random_extent(), random_extent(),
                      4'($urandom_range(15)));
         if (phase == 3) begin
            // Hold the receiver off long enough for the pipeline to fill and stall input.
            long_hold = 120;
         end
         random_phase(95, (phase % 3) == 0);
         if (phase == 6) begin
            // Let everything drain mid-phase before sending more.
            wait_idle();
         end
         random_phase(95, 1'b0);
      end

      wait_idle();
      $display("%0d queries over 15 lattice geometries, %0d responses checked",
               queries_sent, board.answers_seen);
      $display("geometries included degenerate, capped and oversized extents");
      if (board.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

@@ sim.f @@
rtl/lni_pkg.sv
rtl/lni_cfg.sv
rtl/lattice_neighbor_index_core.sv
verif/tb.sv
